// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the Firmata command parser RTL.
// Depends on nothing; define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define FCP_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("fcp assertion failed");

`define FCP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fcp assertion failed");

`else

`define FCP_ASSERT(name, clk, rst_n, prop)
`define FCP_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/fcp_pkg.sv -----
// Types and protocol constants for the Firmata command parser.
// Depends on nothing; used by every module of the block.
`default_nettype none

package fcp_pkg;

	// status bytes, matched on upper nibble below 0xF0
	localparam logic [7:0] ST_PORT_WRITE  = 8'h90;
	localparam logic [7:0] ST_PIN_WRITE   = 8'hE0;
	localparam logic [7:0] ST_REP_ANALOG  = 8'hC0;
	localparam logic [7:0] ST_REP_DIGITAL = 8'hD0;
	localparam logic [7:0] ST_PIN_MODE    = 8'hF4;
	localparam logic [7:0] ST_VERSION     = 8'hF9;
	localparam logic [7:0] ST_SYSEX_START = 8'hF0;
	localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
	localparam logic [7:0] ST_NIBBLE_TOP  = 8'hF0;

	// sysex command bytes
	localparam logic [7:0] SX_EXT_ANALOG  = 8'h6F;
	localparam logic [7:0] SX_FIRMWARE    = 8'h79;
	localparam logic [7:0] SX_MAPPING     = 8'h69;
	localparam logic [7:0] SX_CAPABILITY  = 8'h6B;
	localparam logic [7:0] SX_PIN_STATE   = 8'h6D;

	localparam int CMD_W = 4;

	localparam logic [CMD_W-1:0] CMD_PORT_WRITE  = 4'd0;
	localparam logic [CMD_W-1:0] CMD_PIN_WRITE   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_PIN_MODE    = 4'd2;
	localparam logic [CMD_W-1:0] CMD_VERSION     = 4'd3;
	localparam logic [CMD_W-1:0] CMD_FIRMWARE    = 4'd4;
	localparam logic [CMD_W-1:0] CMD_MAPPING     = 4'd5;
	localparam logic [CMD_W-1:0] CMD_CAPABILITY  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_PIN_STATE   = 4'd7;
	localparam logic [CMD_W-1:0] CMD_REP_ANALOG  = 4'd8;
	localparam logic [CMD_W-1:0] CMD_REP_DIGITAL = 4'd9;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_SYSEX  = 3'd1,
		PH_TARGET = 3'd2,
		PH_FIRST  = 3'd3,
		PH_SECOND = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PORT = 2'd0,
		KIND_PIN  = 2'd1,
		KIND_EXT  = 2'd2,
		KIND_MODE = 2'd3
	} kind_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [7:0]       target;
		logic [7:0]       payload;
		logic             digital_reporting;
		logic             analog_reporting;
	} fcp_result_t;

	// decoder to output register
	typedef struct packed {
		logic        emit;
		fcp_result_t result;
	} fcp_dec_out_t;

endpackage

`default_nettype wire

// ----- rtl/core/fcp_decoder.sv -----
// Protocol state and combinational byte decode of the Firmata command parser.
// Depends on fcp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fcp_decoder (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  enable,
	input  wire [7:0]            rx_byte_s1,
	output fcp_pkg::fcp_dec_out_t dec
);
	import fcp_pkg::*;

	phase_t      phase_q, phase_d;
	kind_t       kind_q, kind_d;
	logic [7:0]  target_q, target_d;
	logic [7:0]  low_q, low_d;
	logic        digital_q, digital_d;
	logic        analog_q, analog_d;
	logic        armed_q, armed_d;
	logic [7:0]  key;
	logic [7:0]  hi;

	// next state
	always_comb begin
		phase_d   = phase_q;
		kind_d    = kind_q;
		target_d  = target_q;
		low_d     = low_q;
		digital_d = digital_q;
		analog_d  = analog_q;
		armed_d   = armed_q;
		key       = (rx_byte_s1 < ST_NIBBLE_TOP) ? {rx_byte_s1[7:4], 4'h0} : rx_byte_s1;
		case (phase_q)
			PH_SYSEX: begin
				phase_d = PH_IDLE;
				case (rx_byte_s1)
					SX_FIRMWARE: begin
						armed_d   = 1'b1;
						digital_d = 1'b0;
						analog_d  = 1'b1;
					end
					SX_PIN_STATE: armed_d = 1'b0;
					SX_EXT_ANALOG: begin
						kind_d  = KIND_EXT;
						phase_d = PH_TARGET;
					end
					default: ;
				endcase
			end
			PH_TARGET: begin
				target_d = rx_byte_s1;
				phase_d  = PH_FIRST;
			end
			PH_FIRST: begin
				if (kind_q == KIND_MODE) begin
					phase_d = PH_IDLE;
				end else begin
					low_d   = rx_byte_s1;
					phase_d = PH_SECOND;
				end
			end
			PH_SECOND: phase_d = PH_IDLE;
			default: begin
				phase_d = PH_IDLE;
				case (key)
					ST_PORT_WRITE, ST_PIN_WRITE: begin
						target_d = {4'h0, rx_byte_s1[3:0]};
						kind_d   = (key == ST_PORT_WRITE) ? KIND_PORT : KIND_PIN;
						phase_d  = PH_FIRST;
					end
					ST_PIN_MODE: begin
						kind_d  = KIND_MODE;
						phase_d = PH_TARGET;
					end
					ST_SYSEX_START: phase_d = PH_SYSEX;
					ST_REP_ANALOG:  analog_d = 1'b1;
					ST_REP_DIGITAL: digital_d = 1'b1;
					default: ;
				endcase
			end
		endcase
	end

	// outputs: record fields, flags taken after this byte's update
	always_comb begin
		dec        = '0;
		hi         = rx_byte_s1;
		case (phase_q)
			PH_SYSEX: begin
				case (rx_byte_s1)
					SX_FIRMWARE: begin
						dec.emit           = 1'b1;
						dec.result.command = CMD_FIRMWARE;
					end
					SX_MAPPING: begin
						dec.emit           = 1'b1;
						dec.result.command = CMD_MAPPING;
					end
					SX_CAPABILITY: begin
						dec.emit           = 1'b1;
						dec.result.command = CMD_CAPABILITY;
					end
					SX_PIN_STATE: begin
						dec.emit           = armed_q;
						dec.result.command = CMD_PIN_STATE;
					end
					default: ;
				endcase
			end
			PH_TARGET: ;
			PH_FIRST: begin
				if (kind_q == KIND_MODE) begin
					dec.emit           = 1'b1;
					dec.result.command = CMD_PIN_MODE;
					dec.result.target  = target_q;
					dec.result.payload = rx_byte_s1;
				end
			end
			PH_SECOND: begin
				// in an extended analog message, an end mark in place of the high byte counts as zero
				if (kind_q == KIND_EXT && rx_byte_s1 == ST_SYSEX_END) begin
					hi = 8'h00;
				end
				dec.emit           = 1'b1;
				dec.result.command = (kind_q == KIND_PORT) ? CMD_PORT_WRITE : CMD_PIN_WRITE;
				dec.result.target  = target_q;
				dec.result.payload = {hi[0], low_q[6:0]};
			end
			default: begin
				case (key)
					ST_VERSION: begin
						dec.emit           = 1'b1;
						dec.result.command = CMD_VERSION;
					end
					ST_REP_ANALOG: begin
						dec.emit           = 1'b1;
						dec.result.command = CMD_REP_ANALOG;
					end
					ST_REP_DIGITAL: begin
						dec.emit           = 1'b1;
						dec.result.command = CMD_REP_DIGITAL;
					end
					default: ;
				endcase
			end
		endcase
		dec.result.digital_reporting = digital_d;
		dec.result.analog_reporting  = analog_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			kind_q    <= KIND_PORT;
			target_q  <= '0;
			low_q     <= '0;
			digital_q <= 1'b0;
			analog_q  <= 1'b0;
			armed_q   <= 1'b1;
		end else if (enable) begin
			phase_q   <= phase_d;
			kind_q    <= kind_d;
			target_q  <= target_d;
			low_q     <= low_d;
			digital_q <= digital_d;
			analog_q  <= analog_d;
			armed_q   <= armed_d;
		end
	end

	`FCP_ASSERT_NEXT(a_pin_state_disarms, clk, arst_n,
		enable && dec.emit && dec.result.command == CMD_PIN_STATE, !armed_q)
	`FCP_ASSERT_NEXT(a_firmware_flags, clk, arst_n,
		enable && dec.emit && dec.result.command == CMD_FIRMWARE,
		armed_q && analog_q && !digital_q)
	`FCP_ASSERT_NEXT(a_sysex_leaves, clk, arst_n, enable && phase_q == PH_SYSEX,
		phase_q == PH_IDLE || phase_q == PH_TARGET)
	`FCP_ASSERT(a_held_flags_stay, clk, arst_n,
		!enable |=> $stable(digital_q) && $stable(analog_q) && $stable(armed_q))

endmodule

`default_nettype wire

// ----- rtl/core/fcp_out_reg.sv -----
// Result register of the Firmata command parser; holds one record until taken.
// Depends on fcp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fcp_out_reg (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  fcp_pkg::fcp_dec_out_t dec,
	output logic                  ready,
	input  wire                   cmd_stall,
	output logic                  cmd_valid,
	output fcp_pkg::fcp_result_t  result
);
	import fcp_pkg::*;

	logic        valid_q;
	fcp_result_t result_q;
	logic        load;

	// the register can take a new record when empty or being emptied
	assign ready     = !valid_q || !cmd_stall;
	assign load      = in_valid && ready && dec.emit;
	assign cmd_valid = valid_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= dec.result;
		end
	end

	`FCP_ASSERT_NEXT(a_load_shows, clk, arst_n, load, valid_q)
	`FCP_ASSERT_NEXT(a_held_record, clk, arst_n, valid_q && cmd_stall,
		valid_q && $stable(result_q))
	`FCP_ASSERT(a_no_load_while_full, clk, arst_n, !(load && valid_q && cmd_stall))

endmodule

`default_nettype wire

// ----- rtl/core/firmata_command_parser.sv -----
// Top level of the Firmata command parser: input register, decoder, result register.
// Depends on fcp_pkg, fcp_decoder, fcp_out_reg and assert_macros.svh.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  rx      | rx_valid, rx_stall, rx_byte               | in
//  cmd     | cmd_valid, cmd_stall, command, target,    | out
//          | payload, digital_reporting,               |
//          | analog_reporting                          |
//
// One byte is taken per cycle while rx_stall is low. A byte is held in the input
// register, is decoded there against the protocol state, and any record it causes
// is loaded into the result register once that register can take it, to show on
// cmd until taken. The input register moves on whenever the result register is
// empty or being taken, so a stall on cmd backs up into rx_stall within the same
// cycle.
// arst_n clears the valid flags and the protocol state (pin-state request armed).
`default_nettype none
`include "assert_macros.svh"

module firmata_command_parser (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        rx_valid,
	output logic                       rx_stall,
	input  wire  [7:0]                 rx_byte,
	output logic                       cmd_valid,
	input  wire                        cmd_stall,
	output logic [fcp_pkg::CMD_W-1:0]  command,
	output logic [7:0]                 target,
	output logic [7:0]                 payload,
	output logic                       digital_reporting,
	output logic                       analog_reporting
);
	import fcp_pkg::*;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          ready;
	logic          accept;
	logic          advance;
	fcp_dec_out_t  dec;
	fcp_result_t   result;

	// hold the input register while its byte cannot move on
	assign rx_stall = valid_s1 && !ready;
	assign accept   = rx_valid && !rx_stall;
	assign advance  = valid_s1 && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready || !valid_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

	// decode and advance the protocol state once per byte
	fcp_decoder u_decoder (
		.clk        (clk),
		.arst_n     (arst_n),
		.enable     (advance),
		.rx_byte_s1 (byte_s1),
		.dec        (dec)
	);

	fcp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.dec       (dec),
		.ready     (ready),
		.cmd_stall (cmd_stall),
		.cmd_valid (cmd_valid),
		.result    (result)
	);

	assign command           = result.command;
	assign target            = result.target;
	assign payload           = result.payload;
	assign digital_reporting = result.digital_reporting;
	assign analog_reporting  = result.analog_reporting;

	`FCP_ASSERT_NEXT(a_accept_fills, clk, arst_n, accept, valid_s1)
	`FCP_ASSERT_NEXT(a_stalled_byte_holds, clk, arst_n, rx_stall,
		valid_s1 && $stable(byte_s1))
	`FCP_ASSERT(a_stall_needs_full, clk, arst_n, !rx_stall || (cmd_valid && cmd_stall))

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for firmata_command_parser: byte stream in, command records out.
// Depends on fcp_pkg for status and sysex codes, command codes and the record type.
// Directed table first, then random message streams checked by a cycle-free predictor.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fcp_pkg::*;

	// Length of the long receiver hold-off, in clock cycles.
	localparam int HOLD_CYCLES = 80;
	// Total number of bytes to push through before winding down.
	localparam int BYTE_TARGET = 830;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             rx_valid = 1'b0;
	logic             rx_stall;
	logic [7:0]       rx_byte = '0;
	logic             cmd_valid;
	logic             cmd_stall = 1'b0;
	logic [CMD_W-1:0] command;
	logic [7:0]       target;
	logic [7:0]       payload;
	logic             digital_reporting;
	logic             analog_reporting;

	firmata_command_parser dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.rx_valid          (rx_valid),
		.rx_stall          (rx_stall),
		.rx_byte           (rx_byte),
		.cmd_valid         (cmd_valid),
		.cmd_stall         (cmd_stall),
		.command           (command),
		.target            (target),
		.payload           (payload),
		.digital_reporting (digital_reporting),
		.analog_reporting  (analog_reporting)
	);

	// Parser state mirrored in the testbench, at its reset values.
	phase_t     parse_phase = PH_IDLE;
	kind_t      parse_kind = KIND_PORT;
	logic [7:0] held_pin = '0;
	logic [7:0] held_low = '0;
	logic       dig_on = 1'b0;
	logic       ana_on = 1'b0;
	logic       state_armed = 1'b1;

	// Records still owed by the block, oldest first.
	fcp_result_t pending_records[$];

	int errors = 0;
	int bytes_sent = 0;
	int records_checked = 0;
	int cmd_count[16];

	// Shared between the sender and the receiver.
	bit calm = 1'b0;     // suppress random idling on both sides
	bit hold_req = 1'b0; // ask the receiver for one long hold-off

	// One row of the directed table: the byte, and where the outcome is
	// obvious, the record typed in by hand (fire low means no record).
	typedef struct packed {
		logic [7:0]  b;
		logic        typed;
		logic        fire;
		fcp_result_t rec;
	} script_row_t;

	localparam int NUM_ROWS = 30;

	script_row_t script_rows [0:NUM_ROWS-1] = '{
		// version request straight after reset, flags still clear
		'{ST_VERSION, 1'b1, 1'b1, '{CMD_VERSION, 8'h00, 8'h00, 1'b0, 1'b0}},
		// pin-state request while armed, then again while disarmed
		'{ST_SYSEX_START, 1'b0, 1'b0, '0},
		'{SX_PIN_STATE, 1'b1, 1'b1, '{CMD_PIN_STATE, 8'h00, 8'h00, 1'b0, 1'b0}},
		'{ST_SYSEX_END, 1'b1, 1'b0, '0},
		'{ST_SYSEX_START, 1'b0, 1'b0, '0},
		'{SX_PIN_STATE, 1'b1, 1'b0, '0},
		// port write on the top port with data bytes that give the maximum payload
		'{ST_PORT_WRITE | 8'h0F, 1'b0, 1'b0, '0},
		'{8'h7F, 1'b0, 1'b0, '0},
		'{8'h01, 1'b1, 1'b1, '{CMD_PORT_WRITE, 8'h0F, 8'hFF, 1'b0, 1'b0}},
		// pin mode with full-range pin and mode bytes
		'{ST_PIN_MODE, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b1, 1'b1, '{CMD_PIN_MODE, 8'hFF, 8'hFF, 1'b0, 1'b0}},
		// extended analog closed early by the end mark, which counts as zero
		'{ST_SYSEX_START, 1'b0, 1'b0, '0},
		'{SX_EXT_ANALOG, 1'b0, 1'b0, '0},
		'{8'h12, 1'b0, 1'b0, '0},
		'{8'h55, 1'b0, 1'b0, '0},
		'{ST_SYSEX_END, 1'b1, 1'b1, '{CMD_PIN_WRITE, 8'h12, 8'h55, 1'b0, 1'b0}},
		// report enables fire at once on the status byte
		'{ST_REP_ANALOG | 8'h05, 1'b1, 1'b1, '{CMD_REP_ANALOG, 8'h00, 8'h00, 1'b0, 1'b1}},
		'{ST_REP_DIGITAL | 8'h03, 1'b1, 1'b1, '{CMD_REP_DIGITAL, 8'h00, 8'h00, 1'b1, 1'b1}},
		// firmware request clears digital, sets analog and re-arms pin state
		'{ST_SYSEX_START, 1'b0, 1'b0, '0},
		'{SX_FIRMWARE, 1'b1, 1'b1, '{CMD_FIRMWARE, 8'h00, 8'h00, 1'b0, 1'b1}},
		'{ST_SYSEX_START, 1'b0, 1'b0, '0},
		'{SX_MAPPING, 1'b1, 1'b1, '{CMD_MAPPING, 8'h00, 8'h00, 1'b0, 1'b1}},
		'{ST_SYSEX_START, 1'b0, 1'b0, '0},
		'{SX_CAPABILITY, 1'b1, 1'b1, '{CMD_CAPABILITY, 8'h00, 8'h00, 1'b0, 1'b1}},
		// unknown sysex command and unknown status byte give nothing
		'{ST_SYSEX_START, 1'b0, 1'b0, '0},
		'{8'h00, 1'b1, 1'b0, '0},
		'{8'hA5, 1'b1, 1'b0, '0},
		// pin state fires again now that the firmware request re-armed it
		'{ST_SYSEX_START, 1'b0, 1'b0, '0},
		'{SX_PIN_STATE, 1'b1, 1'b1, '{CMD_PIN_STATE, 8'h00, 8'h00, 1'b0, 1'b1}}
	};

	// Advance the mirrored parser by one byte; return high when a record results.
	function automatic bit parse_byte(input logic [7:0] b, output fcp_result_t rec);
		logic [7:0] key;
		logic [7:0] hi;
		bit         fire;
		fire = 1'b0;
		rec = '0;
		case (parse_phase)
			PH_SYSEX: begin
				parse_phase = PH_IDLE;
				case (b)
					SX_FIRMWARE: begin
						state_armed = 1'b1;
						dig_on = 1'b0;
						ana_on = 1'b1;
						fire = 1'b1;
						rec.command = CMD_FIRMWARE;
					end
					SX_MAPPING: begin
						fire = 1'b1;
						rec.command = CMD_MAPPING;
					end
					SX_CAPABILITY: begin
						fire = 1'b1;
						rec.command = CMD_CAPABILITY;
					end
					SX_PIN_STATE: begin
						// only one report per arming
						if (state_armed) begin
							state_armed = 1'b0;
							fire = 1'b1;
							rec.command = CMD_PIN_STATE;
						end
					end
					SX_EXT_ANALOG: begin
						parse_kind = KIND_EXT;
						parse_phase = PH_TARGET;
					end
					default: ;
				endcase
			end
			PH_TARGET: begin
				held_pin = b;
				parse_phase = PH_FIRST;
			end
			PH_FIRST: begin
				if (parse_kind == KIND_MODE) begin
					parse_phase = PH_IDLE;
					fire = 1'b1;
					rec.command = CMD_PIN_MODE;
					rec.target = held_pin;
					rec.payload = b;
				end else begin
					held_low = b;
					parse_phase = PH_SECOND;
				end
			end
			PH_SECOND: begin
				parse_phase = PH_IDLE;
				hi = b;
				if (parse_kind == KIND_EXT && hi == ST_SYSEX_END)
					hi = 8'h00;
				fire = 1'b1;
				if (parse_kind == KIND_PORT)
					rec.command = CMD_PORT_WRITE;
				else
					rec.command = CMD_PIN_WRITE;
				rec.target = held_pin;
				rec.payload = {hi[0], held_low[6:0]};
			end
			default: begin
				parse_phase = PH_IDLE;
				key = (b < ST_NIBBLE_TOP) ? {b[7:4], 4'h0} : b;
				case (key)
					ST_PORT_WRITE: begin
						held_pin = {4'h0, b[3:0]};
						parse_kind = KIND_PORT;
						parse_phase = PH_FIRST;
					end
					ST_PIN_WRITE: begin
						held_pin = {4'h0, b[3:0]};
						parse_kind = KIND_PIN;
						parse_phase = PH_FIRST;
					end
					ST_PIN_MODE: begin
						parse_kind = KIND_MODE;
						parse_phase = PH_TARGET;
					end
					ST_SYSEX_START: parse_phase = PH_SYSEX;
					ST_VERSION: begin
						fire = 1'b1;
						rec.command = CMD_VERSION;
					end
					ST_REP_ANALOG: begin
						ana_on = 1'b1;
						fire = 1'b1;
						rec.command = CMD_REP_ANALOG;
					end
					ST_REP_DIGITAL: begin
						dig_on = 1'b1;
						fire = 1'b1;
						rec.command = CMD_REP_DIGITAL;
					end
					default: ;
				endcase
			end
		endcase
		// flags in the record show the state after this byte
		rec.digital_reporting = dig_on;
		rec.analog_reporting = ana_on;
		return fire;
	endfunction

	// Mostly 7-bit data, now and then a full byte, since data is taken blindly.
	function automatic logic [7:0] data_byte();
		if ($urandom_range(99) < 15)
			return 8'($urandom_range(255));
		return 8'($urandom_range(127));
	endfunction

	// Offer one byte, hold it until taken, then book the record it owes.
	// A typed row overrides the predictor's record with the hand-written one.
	task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
			input logic typed_fire = 1'b0, input fcp_result_t typed_rec = '0);
		fcp_result_t rec;
		bit          fire;
		if (!calm && $urandom_range(99) < 13) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (rx_stall) @(posedge clk);
		fire = parse_byte(b, rec);
		if (typed) begin
			fire = typed_fire;
			rec = typed_rec;
		end
		if (fire)
			pending_records.push_back(rec);
		bytes_sent++;
	endtask

	// Build one message, mostly well formed, and send it byte by byte.
	task automatic send_message();
		logic [7:0] msg[$];
		logic [7:0] hi;
		int         pick;
		int         sub;
		pick = $urandom_range(99);
		if (pick < 14) begin
			msg.push_back(ST_PORT_WRITE | 8'($urandom_range(15)));
			msg.push_back(data_byte());
			msg.push_back(data_byte());
		end else if (pick < 28) begin
			msg.push_back(ST_PIN_WRITE | 8'($urandom_range(15)));
			msg.push_back(data_byte());
			msg.push_back(data_byte());
		end else if (pick < 38) begin
			msg.push_back(ST_PIN_MODE);
			msg.push_back(data_byte());
			msg.push_back(data_byte());
		end else if (pick < 44) begin
			msg.push_back(ST_VERSION);
		end else if (pick < 54) begin
			// report enable with its (ignored) data byte
			if ($urandom_range(1))
				msg.push_back(ST_REP_ANALOG | 8'($urandom_range(15)));
			else
				msg.push_back(ST_REP_DIGITAL | 8'($urandom_range(15)));
			msg.push_back(data_byte());
		end else if (pick < 86) begin
			msg.push_back(ST_SYSEX_START);
			sub = $urandom_range(9);
			hi = 8'h00;
			case (sub)
				0, 1: msg.push_back(SX_FIRMWARE);
				2: msg.push_back(SX_MAPPING);
				3: msg.push_back(SX_CAPABILITY);
				4, 5: msg.push_back(SX_PIN_STATE);
				6, 7: begin
					msg.push_back(SX_EXT_ANALOG);
					msg.push_back(data_byte());
					msg.push_back(data_byte());
					// close early with the end mark half of the time
					hi = $urandom_range(1) ? ST_SYSEX_END : data_byte();
					msg.push_back(hi);
				end
				default: msg.push_back(8'($urandom_range(255)));
			endcase
			if (hi != ST_SYSEX_END)
				msg.push_back(ST_SYSEX_END);
		end else begin
			// line noise: any byte value at all
			repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(255)));
		end
		// cut a few messages short to leave the parser mid-sequence
		if (msg.size() > 1 && $urandom_range(99) < 5)
			void'(msg.pop_back());
		foreach (msg[i])
			send_byte(msg[i]);
	endtask

	// Drop valid and wait until every owed record has come out.
	task automatic wait_drained();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (pending_records.size() != 0) @(posedge clk);
	endtask

	task automatic compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name,
				want, got);
			errors++;
		end
	endtask

	// Check one taken record against the oldest one owed.
	task automatic check_record();
		fcp_result_t want;
		if (pending_records.size() == 0) begin
			$display("%0t: record with none owed, expected none, actual cmd %0d tgt %0h pay %0h",
				$realtime, command, target, payload);
			errors++;
			return;
		end
		want = pending_records.pop_front();
		compare_field("command", 8'(want.command), 8'(command));
		compare_field("target", want.target, target);
		compare_field("payload", want.payload, payload);
		compare_field("digital_reporting", 8'(want.digital_reporting),
			8'(digital_reporting));
		compare_field("analog_reporting", 8'(want.analog_reporting), 8'(analog_reporting));
		cmd_count[want.command]++;
		records_checked++;
	endtask

	initial begin
		forever #1 clk = ~clk;
	end

	// Hold reset at the start, then release it for good.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Receiver: take records, stall at random, and honour one long hold-off.
	initial begin : record_sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && cmd_valid && !cmd_stall)
				check_record();
			if (hold_left > 0) begin
				hold_left--;
				cmd_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				cmd_stall <= 1'b1;
			end else begin
				cmd_stall <= !calm && ($urandom_range(99) < 13);
			end
		end
	end

	// Sender: directed table, then random messages, then wind down.
	initial begin : byte_source
		bit held_off;
		bit paused;
		held_off = 1'b0;
		paused = 1'b0;
		@(posedge arst_n);
		@(posedge clk);

		for (int i = 0; i < NUM_ROWS; i++)
			send_byte(script_rows[i].b, script_rows[i].typed, script_rows[i].fire,
				script_rows[i].rec);

		while (bytes_sent < BYTE_TARGET) begin
			// keep offering while the receiver holds off, so the block backs up
			if (!held_off && bytes_sent >= 200) begin
				hold_req = 1'b1;
				held_off = 1'b1;
			end
			// pause once until everything owed has drained
			if (!paused && bytes_sent >= 600) begin
				wait_drained();
				paused = 1'b1;
			end
			// a stretch with no idling on either side
			calm = (bytes_sent >= 350 && bytes_sent < 500);
			send_message();
		end
		calm = 1'b0;

		wait_drained();
		// leave room for any stray record behind the last byte
		repeat (8) @(posedge clk);

		$display("Covered %0d bytes (directed table and random streams), %0d records checked.",
			bytes_sent, records_checked);
		$display("Records per command 0..9: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
			cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], cmd_count[4],
			cmd_count[5], cmd_count[6], cmd_count[7], cmd_count[8], cmd_count[9]);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Give up well after the slowest correct run could end.
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
